/* rtl/core/hbp_pkg.sv */
package hbp_pkg;

  localparam int MAX_CODE_LEN = 32;
  localparam int NUM_SYMBOLS  = 256;

  localparam int SYM_W  = 8;
  localparam int CODE_W = 32;
  localparam int LEN_W  = 6;
  localparam int BYTE_W = 8;
  localparam int PEND_W = 3;
  localparam int IDX_W  = $clog2(CODE_W);
  localparam int ADDR_W = $clog2(NUM_SYMBOLS);
  localparam int ENTRY_W = CODE_W + LEN_W;

  localparam int LEN_BOUND_I = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam logic [LEN_W-1:0] LEN_BOUND = LEN_W'(LEN_BOUND_I);
  localparam logic [SYM_W:0]   SYM_LIMIT = (SYM_W + 1)'(NUM_SYMBOLS);

  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_ENCODE = 2'd1,
    REQ_FLUSH  = 2'd2
  } req_e;

  typedef struct packed {
    logic              start;
    logic              flush;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } pk_cmd_t;

endpackage

/* rtl/core/huffman_bit_packer_core.sv */
// Load transaction: the table is written at the edge that accepts it.
// Encode transaction: a table read in ST_LOOK, then one code bit per cycle while no
//   completed byte waits at the output; each byte registered at the edge of its 8th bit.
// Flush transaction: passes through ST_FLUSH, held there while a byte waits at the output.
// One transaction at a time; shifting stalls only while a completed byte waits.
// Reset clears the accumulator, pending count and control; code table is not cleared.
module huffman_bit_packer_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  req_type_i,
  input  logic [hbp_pkg::SYM_W-1:0]   symbol_i,
  input  logic [hbp_pkg::CODE_W-1:0]  code_bits_i,
  input  logic [hbp_pkg::LEN_W-1:0]   code_len_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [hbp_pkg::BYTE_W-1:0]  out_byte_o,
  output logic                        last_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_LOOK  = 4'b0010,
    ST_SHIFT = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic                          in_accept;
  logic                          sym_ok;
  logic                          ram_we;
  logic                          ram_re;
  logic [hbp_pkg::ADDR_W-1:0]    ram_addr;
  logic [hbp_pkg::LEN_W-1:0]     len_sat;
  logic [hbp_pkg::ENTRY_W-1:0]   ram_wdata;
  logic [hbp_pkg::ENTRY_W-1:0]   ram_rdata;
  hbp_pkg::pk_cmd_t              pk_cmd;
  logic                          pk_busy;
  logic                          out_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_accept  = in_valid_i && in_ready_o;
  assign sym_ok     = ({1'b0, symbol_i} < hbp_pkg::SYM_LIMIT);
  assign ram_addr   = symbol_i[hbp_pkg::ADDR_W-1:0];
  assign len_sat    = (code_len_i > hbp_pkg::LEN_BOUND) ? hbp_pkg::LEN_BOUND : code_len_i;
  assign ram_wdata  = {len_sat, code_bits_i};
  assign out_free   = !out_valid_o || out_ready_i;

  always_comb begin
    state_d = state_q;
    ram_we  = 1'b0;
    ram_re  = 1'b0;
    pk_cmd  = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (req_type_i)
            hbp_pkg::REQ_LOAD: begin
              ram_we = sym_ok;
            end
            hbp_pkg::REQ_ENCODE: begin
              ram_re = sym_ok;
              if (sym_ok) begin
                state_d = ST_LOOK;
              end
            end
            hbp_pkg::REQ_FLUSH: begin
              state_d = ST_FLUSH;
            end
            default: ;
          endcase
        end
      end
      ST_LOOK: begin
        pk_cmd.start = 1'b1;
        pk_cmd.code  = ram_rdata[hbp_pkg::CODE_W-1:0];
        pk_cmd.len   = ram_rdata[hbp_pkg::ENTRY_W-1:hbp_pkg::CODE_W];
        state_d      = ST_SHIFT;
      end
      ST_SHIFT: begin
        if (!pk_busy) begin
          state_d = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          pk_cmd.flush = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  hbp_ram #(
    .Width (hbp_pkg::ENTRY_W),
    .Depth (hbp_pkg::NUM_SYMBOLS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  hbp_packer u_packer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (pk_cmd),
    .busy_o      (pk_busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (last_o)
  );

  a_ready_idle_shifter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !pk_busy)
    else $error("ready while shifter busy");

  a_look_to_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOOK |=> state_q == ST_SHIFT)
    else $error("lookup not followed by shifting");

endmodule

/* rtl/core/hbp_ram.sv */
module hbp_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/hbp_packer.sv */
module hbp_packer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  hbp_pkg::pk_cmd_t            cmd_i,
  output logic                        busy_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [hbp_pkg::BYTE_W-1:0]  out_byte_o,
  output logic                        out_last_o
);

  logic [hbp_pkg::CODE_W-1:0] code_q, code_d;
  logic [hbp_pkg::LEN_W-1:0]  cnt_q, cnt_d;
  logic [hbp_pkg::BYTE_W-1:0] acc_q, acc_d;
  logic [hbp_pkg::PEND_W-1:0] pend_q, pend_d;
  logic                       out_valid_q, out_valid_d;
  logic [hbp_pkg::BYTE_W-1:0] out_byte_q, out_byte_d;
  logic                       out_last_q, out_last_d;

  logic                       out_free;
  logic                       completes;
  logic                       step_en;
  logic                       cur_bit;
  logic [hbp_pkg::IDX_W-1:0]  bit_idx;
  logic [hbp_pkg::BYTE_W-1:0] shifted_acc;
  logic [3:0]                 align_sh;

  assign busy_o      = (cnt_q != '0);
  assign out_free    = !out_valid_q || out_ready_i;
  assign bit_idx     = hbp_pkg::IDX_W'(cnt_q - hbp_pkg::LEN_W'(1));
  assign cur_bit     = code_q[bit_idx];
  assign shifted_acc = {cur_bit, acc_q[hbp_pkg::BYTE_W-1:1]};
  assign completes   = (pend_q == 3'd7);
  assign step_en     = busy_o && (!completes || out_free);
  assign align_sh    = 4'd8 - {1'b0, pend_q};

  always_comb begin
    code_d      = code_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cmd_i.start) begin
      code_d = cmd_i.code;
      cnt_d  = cmd_i.len;
    end else if (cmd_i.flush) begin
      if (pend_q != '0) begin
        out_valid_d = 1'b1;
        out_byte_d  = acc_q >> align_sh;
        out_last_d  = 1'b1;
      end
      acc_d  = '0;
      pend_d = '0;
    end else if (step_en) begin
      cnt_d = cnt_q - hbp_pkg::LEN_W'(1);
      if (completes) begin
        out_valid_d = 1'b1;
        out_byte_d  = shifted_acc;
        out_last_d  = (cnt_q <= hbp_pkg::LEN_W'(8));
        acc_d       = '0;
        pend_d      = '0;
      end else begin
        acc_d  = shifted_acc;
        pend_d = pend_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      acc_q       <= '0;
      pend_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      acc_q       <= acc_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q     <= code_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;

  // flush only issued once the shifter is empty and the output slot is free
  a_flush_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.flush |-> !busy_o && out_free)
    else $error("flush while shifting or output blocked");

  // a byte-completing bit waits while the output slot is held
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o && completes && !out_free && !cmd_i.start |=>
      cnt_q == $past(cnt_q) && pend_q == $past(pend_q))
    else $error("shifter advanced over a blocked output");

endmodule

/* tb/tb_huffman_bit_packer_core.sv */
`timescale 1ns / 100ps

module tb_huffman_bit_packer_core;
  import hbp_pkg::*;

  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int LIMIT_CYCLES   = 400000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int MAX_PRINTS     = 50;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              is_last;
  } packed_byte_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [1:0]          req_type_i;
  logic [SYM_W-1:0]    symbol_i;
  logic [CODE_W-1:0]   code_bits_i;
  logic [LEN_W-1:0]    code_len_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [BYTE_W-1:0]   out_byte_o;
  logic                last_o;

  // packer state as predicted
  logic [CODE_W-1:0]   tbl_code [NUM_SYMBOLS];
  logic [LEN_W-1:0]    tbl_len  [NUM_SYMBOLS];
  logic [BYTE_W-1:0]   acc_byte = '0;
  int                  acc_cnt  = 0;
  packed_byte_t        expected_bytes [$];

  // symbols whose table entry has been written
  bit                  sym_loaded [NUM_SYMBOLS];
  int                  loaded_syms [$];

  int                  mismatch_cnt = 0;
  int                  cycle_cnt    = 0;
  bit                  src_idle_en  = 1'b1;
  bit                  rx_idle_en   = 1'b1;
  bit                  rx_hold_req  = 1'b0;

  huffman_bit_packer_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .symbol_i    (symbol_i),
    .code_bits_i (code_bits_i),
    .code_len_i  (code_len_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_PRINTS) begin
      $display("[%0t] %s", $time, msg);
    end
  endtask

  function automatic void pack_request(input logic [1:0] req, input logic [SYM_W-1:0] sym,
                                       input logic [CODE_W-1:0] bits,
                                       input logic [LEN_W-1:0] len);
    packed_byte_t burst [$];
    packed_byte_t pb;
    case (req)
      REQ_LOAD: begin
        tbl_code[sym] = bits;
        tbl_len[sym]  = (len > LEN_BOUND) ? LEN_BOUND : len;
      end
      REQ_ENCODE: begin
        for (int i = int'(tbl_len[sym]); i > 0; i--) begin
          acc_byte = {tbl_code[sym][i-1], acc_byte[BYTE_W-1:1]};
          acc_cnt++;
          if (acc_cnt == BYTE_W) begin
            pb.data    = acc_byte;
            pb.is_last = 1'b0;
            burst.push_back(pb);
            acc_byte = '0;
            acc_cnt  = 0;
          end
        end
        if (burst.size() > 0) begin
          burst[burst.size()-1].is_last = 1'b1;
        end
        foreach (burst[k]) expected_bytes.push_back(burst[k]);
      end
      REQ_FLUSH: begin
        if (acc_cnt > 0) begin
          pb.data    = acc_byte >> (BYTE_W - acc_cnt);
          pb.is_last = 1'b1;
          expected_bytes.push_back(pb);
          acc_byte = '0;
          acc_cnt  = 0;
        end
      end
      default: begin
      end
    endcase
  endfunction

  task automatic check_out_byte(input logic [BYTE_W-1:0] got_byte, input logic got_last);
    packed_byte_t exp;
    if (expected_bytes.size() == 0) begin
      report_mismatch($sformatf("unexpected byte %02h last %0b", got_byte, got_last));
      return;
    end
    exp = expected_bytes.pop_front();
    if (got_byte !== exp.data) begin
      report_mismatch($sformatf("out_byte %02h, expected %02h", got_byte, exp.data));
    end
    if (got_last !== exp.is_last) begin
      report_mismatch($sformatf("last %0b, expected %0b (byte %02h)", got_last, exp.is_last,
                                exp.data));
    end
  endtask

  // output side checked before the new transaction is predicted
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
        check_out_byte(out_byte_o, last_o);
      end
      if (in_valid_i === 1'b1 && in_ready_o === 1'b1) begin
        pack_request(req_type_i, symbol_i, code_bits_i, code_len_i);
      end
    end
  end

  initial begin : rx_driver
    int gap;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (rx_hold_req) begin
        out_ready_i <= 1'b0;
        for (int c = 0; c < RX_HOLD_CYCLES; c++) @(posedge clk_i);
        rx_hold_req = 1'b0;
        out_ready_i <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
        gap = $urandom_range(1, 14);
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic send_request(input logic [1:0] req, input logic [SYM_W-1:0] sym,
                              input logic [CODE_W-1:0] bits, input logic [LEN_W-1:0] len);
    int gap;
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    req_type_i  <= req;
    symbol_i    <= sym;
    code_bits_i <= bits;
    code_len_i  <= len;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    if (req == REQ_LOAD && !sym_loaded[sym]) begin
      sym_loaded[sym] = 1'b1;
      loaded_syms.push_back(sym);
    end
  endtask

  function automatic logic [LEN_W-1:0] pick_code_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 70) return LEN_W'($urandom_range(1, 12));
    if (r < 90) return LEN_W'($urandom_range(13, 32));
    return LEN_W'($urandom_range(33, 63));
  endfunction

  task automatic send_random_item();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12 || loaded_syms.size() == 0) begin
      send_request(REQ_LOAD, SYM_W'($urandom()), $urandom(), pick_code_len());
    end else if (r < 80) begin
      send_request(REQ_ENCODE, SYM_W'(loaded_syms[$urandom_range(0, loaded_syms.size()-1)]),
                   $urandom(), LEN_W'($urandom()));
    end else if (r < 94) begin
      send_request(REQ_FLUSH, SYM_W'($urandom()), $urandom(), LEN_W'($urandom()));
    end else begin
      send_request(REQ_UNKNOWN, SYM_W'($urandom()), $urandom(), LEN_W'($urandom()));
    end
  endtask

  task automatic test_directed_corners();
    send_request(REQ_FLUSH, 8'h00, 32'h0, 6'd0);
    send_request(REQ_UNKNOWN, 8'h5A, $urandom(), 6'd17);
    send_request(REQ_LOAD, 8'h00, 32'hFFFF_FFFF, 6'd0);
    send_request(REQ_LOAD, 8'hFF, 32'hFFFF_FFFF, 6'd32);
    send_request(REQ_LOAD, 8'h01, 32'h0000_0001, 6'd1);
    send_request(REQ_LOAD, 8'h02, 32'hA5C3_5A3C, 6'd63);
    send_request(REQ_LOAD, 8'h03, 32'h0000_0000, 6'd7);
    send_request(REQ_LOAD, 8'h80, 32'hFFFF_FF55, 6'd8);
    send_request(REQ_ENCODE, 8'h00, 32'h0, 6'd0);
    send_request(REQ_ENCODE, 8'h03, 32'h0, 6'd0);
    send_request(REQ_ENCODE, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
    send_request(REQ_FLUSH, 8'h00, 32'h0, 6'd0);
    send_request(REQ_ENCODE, 8'h01, 32'h0, 6'd0);
    send_request(REQ_FLUSH, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
    send_request(REQ_ENCODE, 8'h02, 32'h0, 6'd0);
    send_request(REQ_ENCODE, 8'h80, 32'h0, 6'd0);
    send_request(REQ_FLUSH, 8'h00, 32'h0, 6'd0);
    send_request(REQ_UNKNOWN, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
    send_request(REQ_LOAD, 8'h2A, 32'h1234_5678, 6'd33);
    send_request(REQ_ENCODE, 8'h2A, 32'h0, 6'd0);
    send_request(REQ_FLUSH, 8'h00, 32'h0, 6'd0);
  endtask

  // receiver stops for a long stretch while long codes keep arriving
  task automatic test_output_stall_fill();
    src_idle_en = 1'b0;
    rx_idle_en  = 1'b0;
    send_request(REQ_LOAD, 8'hC7, $urandom(), 6'd32);
    send_request(REQ_LOAD, 8'h3B, $urandom(), 6'd29);
    rx_hold_req = 1'b1;
    for (int n = 0; n < 12; n++) begin
      send_request(REQ_ENCODE, n[0] ? 8'hC7 : 8'h3B, $urandom(), LEN_W'($urandom()));
    end
    send_request(REQ_FLUSH, 8'h00, 32'h0, 6'd0);
    src_idle_en = 1'b1;
    rx_idle_en  = 1'b1;
  endtask

  task automatic test_random_traffic(input int count);
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) begin
        src_idle_en = ($urandom_range(0, 3) != 0);
        rx_idle_en  = ($urandom_range(0, 3) != 0);
      end
      send_random_item();
    end
  endtask

  task automatic test_quiet_tail(input int count);
    src_idle_en = 1'b0;
    rx_idle_en  = 1'b0;
    for (int n = 0; n < count; n++) send_random_item();
    send_request(REQ_FLUSH, 8'h00, 32'h0, 6'd0);
  endtask

  initial begin : stimulus
    in_valid_i  <= 1'b0;
    req_type_i  <= REQ_LOAD;
    symbol_i    <= '0;
    code_bits_i <= '0;
    code_len_i  <= '0;
    rst_ni      <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_corners();
    test_output_stall_fill();
    test_random_traffic(340);
    test_quiet_tail(60);

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_bytes.size() != 0) begin
      report_mismatch($sformatf("%0d expected bytes never arrived", expected_bytes.size()));
    end
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
